/* hw/rtl/fglc_pkg.sv */
// Shared types, constants and power tables for the block group layout calculator.
// Used by fglc_ctrl, fglc_dp and fs_group_layout_calc_core.
package fglc_pkg;

  localparam int unsigned DivBits = 48;
  localparam int unsigned CntW    = 6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_GC,
    ST_MUL,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CFG_TOTAL_BLOCKS,
    CFG_BLOCKS_PER_GROUP,
    CFG_TOTAL_INODES,
    CFG_INODES_PER_GROUP,
    CFG_LOG_DESC_PER_BLOCK,
    CFG_LAYOUT_FLAGS,
    CFG_FIRST_META_BG,
    CFG_RESERVED_GDT_BLOCKS
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic gc_calc;
    logic mul_calc;
    logic fin_calc;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

  // power k+1 of each base, zero past the 32-bit range
  function automatic logic [31:0] pow3(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd3;
      5'd1:  v = 32'd9;
      5'd2:  v = 32'd27;
      5'd3:  v = 32'd81;
      5'd4:  v = 32'd243;
      5'd5:  v = 32'd729;
      5'd6:  v = 32'd2187;
      5'd7:  v = 32'd6561;
      5'd8:  v = 32'd19683;
      5'd9:  v = 32'd59049;
      5'd10: v = 32'd177147;
      5'd11: v = 32'd531441;
      5'd12: v = 32'd1594323;
      5'd13: v = 32'd4782969;
      5'd14: v = 32'd14348907;
      5'd15: v = 32'd43046721;
      5'd16: v = 32'd129140163;
      5'd17: v = 32'd387420489;
      5'd18: v = 32'd1162261467;
      5'd19: v = 32'd3486784401;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pow5(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd5;
      5'd1:  v = 32'd25;
      5'd2:  v = 32'd125;
      5'd3:  v = 32'd625;
      5'd4:  v = 32'd3125;
      5'd5:  v = 32'd15625;
      5'd6:  v = 32'd78125;
      5'd7:  v = 32'd390625;
      5'd8:  v = 32'd1953125;
      5'd9:  v = 32'd9765625;
      5'd10: v = 32'd48828125;
      5'd11: v = 32'd244140625;
      5'd12: v = 32'd1220703125;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pow7(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd7;
      5'd1:  v = 32'd49;
      5'd2:  v = 32'd343;
      5'd3:  v = 32'd2401;
      5'd4:  v = 32'd16807;
      5'd5:  v = 32'd117649;
      5'd6:  v = 32'd823543;
      5'd7:  v = 32'd5764801;
      5'd8:  v = 32'd40353607;
      5'd9:  v = 32'd282475249;
      5'd10: v = 32'd1977326743;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/fglc_ctrl.sv */
// Sequencer for the block group layout calculator.
// Depends on fglc_pkg; drives fglc_dp through cmd_t and reads sts_t.
module fglc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output fglc_pkg::cmd_t cmd,
  input  fglc_pkg::sts_t sts
);

  fglc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fglc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      fglc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = fglc_pkg::ST_DIV;
        end
      end
      fglc_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = fglc_pkg::ST_GC;
        end
      end
      fglc_pkg::ST_GC: begin
        cmd.gc_calc = 1'b1;
        state_nxt   = fglc_pkg::ST_MUL;
      end
      fglc_pkg::ST_MUL: begin
        cmd.mul_calc = 1'b1;
        state_nxt    = fglc_pkg::ST_FIN;
      end
      fglc_pkg::ST_FIN: begin
        cmd.fin_calc = 1'b1;
        state_nxt    = fglc_pkg::ST_OUT;
      end
      fglc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = fglc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fglc_pkg::ST_IDLE;
    endcase
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fglc_pkg::ST_OUT && out_stall) |=> state_r == fglc_pkg::ST_OUT)
    else $error("result dropped while stalled");

  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == fglc_pkg::ST_DIV)
    else $error("transfer did not start division");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fglc_pkg::ST_DIV && sts.div_last) |=> state_r == fglc_pkg::ST_GC)
    else $error("division did not finish");

endmodule

/* hw/rtl/fglc_dp.sv */
// Datapath: configuration registers, serial divider, power scan and result logic.
// Depends on fglc_pkg; controlled by fglc_ctrl.
module fglc_dp (
  input  logic           clk,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_addr,
  input  logic [47:0]    cfg_data,
  input  logic [31:0]    in_group_index,
  input  fglc_pkg::cmd_t cmd,
  output fglc_pkg::sts_t sts,
  input  logic           rst_n,
  output logic [31:0]    out_group_count,
  output logic [31:0]    out_blocks_in_group,
  output logic [31:0]    out_inodes_in_group,
  output logic           out_has_super_copy,
  output logic [31:0]    out_desc_blocks,
  output logic [31:0]    out_base_meta_clusters
);

  logic [47:0] total_blocks_r;
  logic [19:0] bpg_r;
  logic [31:0] total_inodes_r;
  logic [19:0] ipg_r;
  logic [3:0]  ldpb_r;
  logic [5:0]  flags_r;
  logic [31:0] fmb_r;
  logic [15:0] rsv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_blocks_r <= '0;
      bpg_r          <= 20'd32768;
      total_inodes_r <= '0;
      ipg_r          <= 20'd8192;
      ldpb_r         <= 4'd7;
      flags_r        <= 6'd1;
      fmb_r          <= '0;
      rsv_r          <= '0;
    end else if (cfg_we) begin
      case (fglc_pkg::cfg_idx_t'(cfg_addr))
        fglc_pkg::CFG_TOTAL_BLOCKS:        total_blocks_r <= cfg_data;
        fglc_pkg::CFG_BLOCKS_PER_GROUP:    bpg_r          <= cfg_data[19:0];
        fglc_pkg::CFG_TOTAL_INODES:        total_inodes_r <= cfg_data[31:0];
        fglc_pkg::CFG_INODES_PER_GROUP:    ipg_r          <= cfg_data[19:0];
        fglc_pkg::CFG_LOG_DESC_PER_BLOCK:  ldpb_r         <= cfg_data[3:0];
        fglc_pkg::CFG_LAYOUT_FLAGS:        flags_r        <= cfg_data[5:0];
        fglc_pkg::CFG_FIRST_META_BG:       fmb_r          <= cfg_data[31:0];
        fglc_pkg::CFG_RESERVED_GDT_BLOCKS: rsv_r          <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] g_r;
  logic [47:0] dvd_r;
  logic [20:0] rem_r;
  logic [fglc_pkg::CntW-1:0] cnt_r;
  logic        hit_r;
  logic [31:0] gc_r, pb_r, pi_r;

  logic [20:0] rem_sh;
  logic        qbit;
  logic        hit_now;

  assign rem_sh  = {rem_r[19:0], dvd_r[47]};
  assign qbit    = rem_sh >= {1'b0, bpg_r};
  assign hit_now = (g_r == fglc_pkg::pow3(cnt_r[4:0])) ||
                   (g_r == fglc_pkg::pow5(cnt_r[4:0])) ||
                   (g_r == fglc_pkg::pow7(cnt_r[4:0]));
  assign sts.div_last = cnt_r == fglc_pkg::CntW'(fglc_pkg::DivBits - 1);

  logic [31:0] lastidx;
  logic [51:0] pb_full, pi_full;
  assign lastidx = gc_r - 32'd1;
  assign pb_full = lastidx * bpg_r;
  assign pi_full = lastidx * ipg_r;

  logic        lt, sparse, sup, meta;
  logic [31:0] dpb, mg, first, last, gdb, num, num_cl, blocks, inodes;
  logic [3:0]  sh;

  always_comb begin
    lt     = g_r < lastidx;
    blocks = lt ? {12'd0, bpg_r} : total_blocks_r[31:0] - pb_r;
    inodes = lt ? {12'd0, ipg_r} : total_inodes_r - pi_r;
    sparse = (g_r <= 32'd1) || hit_r;
    sup    = !flags_r[0] || sparse;
    meta   = flags_r[1];
    dpb    = 32'd1 << ldpb_r;
    mg     = g_r >> ldpb_r;
    first  = mg << ldpb_r;
    last   = first + dpb - 32'd1;
    if (!meta || mg < fmb_r) begin
      if (!sup) begin
        gdb = '0;
      end else if (meta) begin
        gdb = fmb_r;
      end else begin
        gdb = (gc_r + dpb - 32'd1) >> ldpb_r;
      end
    end else begin
      gdb = (g_r == first || g_r == first + 32'd1 || g_r == last) ? 32'd1 : 32'd0;
    end
    if (!meta || g_r < (fmb_r << ldpb_r)) begin
      num = sup ? 32'd1 + gdb + {16'd0, rsv_r} : 32'd0;
    end else begin
      num = {31'd0, sup} + gdb;
    end
    sh     = flags_r[5:2];
    num_cl = (num + ((32'd1 << sh) - 32'd1)) >> sh;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      g_r   <= in_group_index;
      dvd_r <= total_blocks_r;
      rem_r <= '0;
      cnt_r <= '0;
      hit_r <= 1'b0;
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? rem_sh - {1'b0, bpg_r} : rem_sh;
      dvd_r <= {dvd_r[46:0], qbit};
      cnt_r <= cnt_r + 1'b1;
      hit_r <= hit_r | hit_now;
    end
    if (cmd.gc_calc) begin
      gc_r <= (bpg_r == '0) ? 32'd0 : dvd_r[31:0] + {31'd0, rem_r != '0};
    end
    if (cmd.mul_calc) begin
      pb_r <= pb_full[31:0];
      pi_r <= pi_full[31:0];
    end
    if (cmd.fin_calc) begin
      out_group_count        <= gc_r;
      out_blocks_in_group    <= blocks;
      out_inodes_in_group    <= inodes;
      out_has_super_copy     <= sup;
      out_desc_blocks        <= gdb;
      out_base_meta_clusters <= num_cl;
    end
  end

endmodule

/* hw/rtl/fs_group_layout_calc_core.sv */
// Top level of the block group layout calculator.
// Depends on fglc_pkg, fglc_ctrl and fglc_dp.
// One group index is taken at a time; its result comes from the 48-step
// serial division of total blocks by blocks per group (the power-of-3/5/7
// table scan runs alongside it), followed by a group count step, a step for
// the two products and a final result step, which registers the outputs. The next
// index is taken the cycle after the result transfer.
module fs_group_layout_calc_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_group_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_group_count,
  output logic [31:0] out_blocks_in_group,
  output logic [31:0] out_inodes_in_group,
  output logic        out_has_super_copy,
  output logic [31:0] out_desc_blocks,
  output logic [31:0] out_base_meta_clusters
);

  fglc_pkg::cmd_t cmd;
  fglc_pkg::sts_t sts;

  fglc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  fglc_dp u_dp (
    .clk                    (clk),
    .cfg_we                 (cfg_we),
    .cfg_addr               (cfg_addr),
    .cfg_data               (cfg_data),
    .in_group_index         (in_group_index),
    .cmd                    (cmd),
    .sts                    (sts),
    .rst_n                  (rst_n),
    .out_group_count        (out_group_count),
    .out_blocks_in_group    (out_blocks_in_group),
    .out_inodes_in_group    (out_inodes_in_group),
    .out_has_super_copy     (out_has_super_copy),
    .out_desc_blocks        (out_desc_blocks),
    .out_base_meta_clusters (out_base_meta_clusters)
  );

endmodule
